// ----- hdl/lbc_pkg.sv -----
// Package for the multi-channel LED blink controller.
// Holds the field widths, default parameters, command codes and the per-channel command struct.
// No dependencies.
package lbc_pkg;

    // Default parameter values for the top level
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int PERIOD_BITS_DEF  = 16;

    // Field widths of the request and result items
    localparam int MODE_W         = 3;
    localparam int CHANNEL_W      = 2;
    localparam int BLINK_PERIOD_W = 16;
    localparam int LED_MASK_W     = 4;

    // Stream data widths, packed fields padded to whole bytes
    localparam int S_FIELDS_W = MODE_W + CHANNEL_W + BLINK_PERIOD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((LED_MASK_W + 7) / 8) * 8;

    // Command codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK       = 3'd0,
        MODE_ON         = 3'd1,
        MODE_OFF        = 3'd2,
        MODE_TOGGLE     = 3'd3,
        MODE_ALL_ON     = 3'd4,
        MODE_ALL_OFF    = 3'd5,
        MODE_BLINK      = 3'd6,
        MODE_STOP_BLINK = 3'd7
    } mode_t;

    // Decoded command for one channel; at most one flag is set in a cycle
    typedef struct packed {
        logic tick;
        logic set_on;
        logic set_off;
        logic toggle;
        logic arm;
        logic stop;
    } chan_cmd_t;

endpackage

// ----- hdl/multi_channel_led_blink_controller_unit.sv -----
// The controller takes one request per clock cycle, every cycle, as long as results are taken.
// A request is held in an input register until the output register is free; then all channels
// update their level, blink enable and tick counter in parallel, and the new LED mask is
// written to the output register, which drives m_tvalid. This update of the per-channel
// registers, done together with the move into the output register, sets this rate. Each
// request, tick or command, gives exactly one result: the levels of channels 0 to 3 after it.

// Top level of the multi-channel LED blink controller.
// Depends on lbc_pkg and lbc_channel.
module multi_channel_led_blink_controller_unit #(
    parameter int NUM_CHANNELS = lbc_pkg::NUM_CHANNELS_DEF,
    parameter int PERIOD_BITS  = lbc_pkg::PERIOD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: mode [2:0], channel [4:3], blink_period [20:5], zeros above
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lbc_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: led_mask [3:0], zeros above
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lbc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int MODE_LO   = 0;
    localparam int CHAN_LO   = MODE_LO + lbc_pkg::MODE_W;
    localparam int PERIOD_LO = CHAN_LO + lbc_pkg::CHANNEL_W;

    logic                                in_valid_reg;
    logic [lbc_pkg::MODE_W-1:0]          in_mode_reg;
    logic [lbc_pkg::CHANNEL_W-1:0]       in_channel_reg;
    logic [lbc_pkg::BLINK_PERIOD_W-1:0]  in_period_reg;
    logic                                out_valid_reg;
    logic [lbc_pkg::LED_MASK_W-1:0]      out_mask_reg;
    logic                                advance;
    lbc_pkg::mode_t                      mode;
    logic [PERIOD_BITS-1:0]              period;
    logic [NUM_CHANNELS-1:0]             level_next;
    logic [lbc_pkg::LED_MASK_W-1:0]      mask_next;

    // Pipeline control: the held request moves on when the output register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lbc_pkg::M_TDATA_W - lbc_pkg::LED_MASK_W){1'b0}}, out_mask_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input register for the request fields
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg    <= s_tdata[MODE_LO +: lbc_pkg::MODE_W];
            in_channel_reg <= s_tdata[CHAN_LO +: lbc_pkg::CHANNEL_W];
            in_period_reg  <= s_tdata[PERIOD_LO +: lbc_pkg::BLINK_PERIOD_W];
        end
    end

    // Output register for the LED mask after the update
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_mask_reg <= mask_next;
        end
    end

    assign mode = lbc_pkg::mode_t'(in_mode_reg);

    // Blink period fitted to the counter width
    assign period = PERIOD_BITS'(in_period_reg);

    // Per-channel command decode and channel engines
    generate
        for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_chan
            localparam bit IN_GROUP = (ch != 0);
            logic               sel;
            lbc_pkg::chan_cmd_t cmd;

            assign sel = (32'(in_channel_reg) == ch);

            always_comb begin
                cmd = '0;
                if (advance) begin
                    unique case (mode)
                        lbc_pkg::MODE_TICK:       cmd.tick    = 1'b1;
                        lbc_pkg::MODE_ON:         cmd.set_on  = sel;
                        lbc_pkg::MODE_OFF:        cmd.set_off = sel;
                        lbc_pkg::MODE_TOGGLE:     cmd.toggle  = sel;
                        lbc_pkg::MODE_ALL_ON:     cmd.set_on  = IN_GROUP;
                        lbc_pkg::MODE_ALL_OFF:    cmd.set_off = IN_GROUP;
                        lbc_pkg::MODE_BLINK:      cmd.arm     = sel;
                        lbc_pkg::MODE_STOP_BLINK: cmd.stop    = sel;
                        default:                  cmd = '0;
                    endcase
                end
            end

            lbc_channel #(
                .PERIOD_BITS(PERIOD_BITS)
            ) u_channel (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .period     (period),
                .level_next (level_next[ch])
            );
        end
    endgenerate

    // Visible mask: channels 0 to 3, zero where a channel does not exist
    generate
        for (genvar b = 0; b < lbc_pkg::LED_MASK_W; b++) begin : g_mask
            if (b < NUM_CHANNELS) begin : g_used
                assign mask_next[b] = level_next[b];
            end else begin : g_unused
                assign mask_next[b] = 1'b0;
            end
        end
    endgenerate

`ifndef NO_ASSERTIONS
    // A request that moves on always yields a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("request advanced without a result");

    // An empty input register never blocks the slave side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    // Switching channel 0 on shows in the next result
    a_on_channel0: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_mode_reg == lbc_pkg::MODE_ON && in_channel_reg == '0)
        |=> out_mask_reg[0])
        else $error("channel 0 not lit after on request");

    // All-off leaves channel 0 untouched and clears channel 1
    a_all_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_mode_reg == lbc_pkg::MODE_ALL_OFF)
        |=> (!out_mask_reg[1] && out_mask_reg[0] == $past(level_next[0])))
        else $error("all-off request handled wrongly");
`endif

endmodule

// ----- hdl/lbc_channel.sv -----
// One LED channel: output level, blink enable, elapsed tick counter and stored period.
// Depends on lbc_pkg for the decoded command struct.
module lbc_channel #(
    parameter int PERIOD_BITS = lbc_pkg::PERIOD_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lbc_pkg::chan_cmd_t     cmd,
    input  logic [PERIOD_BITS-1:0] period,
    output logic                   level_next
);

    logic                   level_reg;
    logic                   enable_reg;
    logic                   enable_next;
    logic [PERIOD_BITS-1:0] elapsed_reg;
    logic [PERIOD_BITS-1:0] elapsed_next;
    logic [PERIOD_BITS-1:0] period_reg;
    logic [PERIOD_BITS-1:0] period_next;
    logic [PERIOD_BITS-1:0] elapsed_inc;
    logic                   wrap;

    // Saturating count of ticks and the check against the stored period
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign wrap        = (elapsed_inc >= period_reg);

    // Next state of the channel for the current command
    always_comb begin
        level_next   = level_reg;
        enable_next  = enable_reg;
        elapsed_next = elapsed_reg;
        period_next  = period_reg;
        priority if (cmd.tick) begin
            if (enable_reg) begin
                if (wrap) begin
                    level_next   = ~level_reg;
                    elapsed_next = '0;
                end else begin
                    elapsed_next = elapsed_inc;
                end
            end
        end else if (cmd.set_on) begin
            level_next  = 1'b1;
            enable_next = 1'b0;
        end else if (cmd.set_off) begin
            level_next  = 1'b0;
            enable_next = 1'b0;
        end else if (cmd.toggle) begin
            level_next = ~level_reg;
        end else if (cmd.arm) begin
            period_next  = period;
            elapsed_next = '0;
            enable_next  = 1'b1;
        end else if (cmd.stop) begin
            level_next  = 1'b0;
            enable_next = 1'b0;
        end else begin
            level_next = level_reg;
        end
    end

    // Control state is reset; the counter and period are always loaded before use
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= 1'b0;
            enable_reg <= 1'b0;
        end else begin
            level_reg  <= level_next;
            enable_reg <= enable_next;
        end
    end

    always_ff @(posedge aclk) begin
        elapsed_reg <= elapsed_next;
        period_reg  <= period_next;
    end

endmodule

// ----- verif/multi_channel_led_blink_controller_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the multi-channel LED blink controller: directed and random requests,
// with every returned LED mask checked against a predictor of the channel state.
// Depends on lbc_pkg and multi_channel_led_blink_controller_unit.
module multi_channel_led_blink_controller_unit_tb;

    localparam int CHANNELS     = lbc_pkg::NUM_CHANNELS_DEF;
    localparam int CNT_W        = lbc_pkg::PERIOD_BITS_DEF;
    localparam int MASK_W       = lbc_pkg::LED_MASK_W;
    localparam int LONG_PERIOD  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 100000;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [lbc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [lbc_pkg::M_TDATA_W-1:0] m_tdata;

    // Predicted channel state
    logic [CHANNELS-1:0]    led_levels;
    logic                   blink_armed [CHANNELS];
    logic [CNT_W-1:0]       tick_count [CHANNELS];
    logic [CNT_W-1:0]       blink_interval [CHANNELS];

    // Masks still owed by the block, oldest first
    logic [MASK_W-1:0]      expected_masks [$];
    int                     mismatches = 0;

    // Sender pacing
    int                     burst_left   = 0;
    bit                     gaps_enabled = 1'b1;

    multi_channel_led_blink_controller_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Applies one request to the predicted state and returns the visible LED mask.
    function automatic logic [MASK_W-1:0] apply_request(lbc_pkg::mode_t mode, logic [1:0] ch,
                                                         logic [15:0] period);
        int unsigned idx;
        idx = ch;
        case (mode)
            lbc_pkg::MODE_TICK: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (blink_armed[i]) begin
                        if (tick_count[i] != '1) tick_count[i] = tick_count[i] + 1'b1;
                        if (tick_count[i] >= blink_interval[i]) begin
                            led_levels[i] = ~led_levels[i];
                            tick_count[i] = '0;
                        end
                    end
                end
            end
            lbc_pkg::MODE_ON: begin
                if (idx < CHANNELS) begin
                    led_levels[idx]  = 1'b1;
                    blink_armed[idx] = 1'b0;
                end
            end
            lbc_pkg::MODE_OFF: begin
                if (idx < CHANNELS) begin
                    led_levels[idx]  = 1'b0;
                    blink_armed[idx] = 1'b0;
                end
            end
            lbc_pkg::MODE_TOGGLE: begin
                if (idx < CHANNELS) led_levels[idx] = ~led_levels[idx];
            end
            lbc_pkg::MODE_ALL_ON, lbc_pkg::MODE_ALL_OFF: begin
                // Channel 0 is the power LED and is never touched by group commands.
                for (int i = 1; i < CHANNELS; i++) begin
                    led_levels[i]  = (mode == lbc_pkg::MODE_ALL_ON);
                    blink_armed[i] = 1'b0;
                end
            end
            lbc_pkg::MODE_BLINK: begin
                if (idx < CHANNELS) begin
                    blink_interval[idx] = CNT_W'(period);
                    tick_count[idx]     = '0;
                    blink_armed[idx]    = 1'b1;
                end
            end
            default: begin
                if (idx < CHANNELS) begin
                    blink_armed[idx] = 1'b0;
                    led_levels[idx]  = 1'b0;
                end
            end
        endcase
        return MASK_W'(led_levels);
    endfunction

    // Sends one request, with a random gap at the start of each burst, and records
    // the mask it must produce once the block has accepted it.
    task automatic send_request(lbc_pkg::mode_t mode, logic [1:0] ch, logic [15:0] period);
        int gap;
        if (gaps_enabled && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(lbc_pkg::S_TDATA_W - lbc_pkg::S_FIELDS_W){1'b0}}, period, ch, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_masks.push_back(apply_request(mode, ch, period));
    endtask

    // A tick carries random filler in the fields it does not use.
    task automatic send_tick();
        send_request(lbc_pkg::MODE_TICK, 2'($urandom_range(0, 3)), 16'($urandom));
    endtask

    // Single-channel on for every channel, then toggle, off and stop-blink on single channels.
    task automatic test_single_commands();
        for (int i = 0; i < CHANNELS; i++) send_request(lbc_pkg::MODE_ON, 2'(i), 16'h0000);
        send_request(lbc_pkg::MODE_TOGGLE, 2'd1, 16'hFFFF);
        send_request(lbc_pkg::MODE_OFF, 2'd2, 16'h0000);
        send_request(lbc_pkg::MODE_TOGGLE, 2'd2, 16'h0000);
        send_request(lbc_pkg::MODE_STOP_BLINK, 2'd3, 16'h0000);
        send_request(lbc_pkg::MODE_OFF, 2'd0, 16'hFFFF);
    endtask

    // Group commands leave the power LED alone and cancel blinking on the others.
    task automatic test_group_commands();
        send_request(lbc_pkg::MODE_ON, 2'd0, 16'h0000);
        send_request(lbc_pkg::MODE_ALL_OFF, 2'd0, 16'h0000);
        send_request(lbc_pkg::MODE_BLINK, 2'd1, 16'h0000);
        send_request(lbc_pkg::MODE_ALL_ON, 2'd3, 16'h0000);
        send_tick();
        send_request(lbc_pkg::MODE_ALL_OFF, 2'd1, 16'h0000);
    endtask

    // A zero interval toggles on every tick; toggle mid-blink keeps the blink running.
    task automatic test_zero_period();
        send_request(lbc_pkg::MODE_BLINK, 2'd2, 16'h0000);
        repeat (3) send_tick();
        send_request(lbc_pkg::MODE_TOGGLE, 2'd2, 16'h0000);
        send_tick();
        send_request(lbc_pkg::MODE_STOP_BLINK, 2'd2, 16'h0000);
        send_tick();
    endtask

    // Short intervals, re-arming mid-count and off cancelling a blink.
    task automatic test_blink_intervals();
        send_request(lbc_pkg::MODE_BLINK, 2'd1, 16'd3);
        send_request(lbc_pkg::MODE_BLINK, 2'd0, 16'd1);
        repeat (2) send_tick();
        send_request(lbc_pkg::MODE_BLINK, 2'd1, 16'd2);
        repeat (5) send_tick();
        send_request(lbc_pkg::MODE_OFF, 2'd0, 16'h0000);
        send_request(lbc_pkg::MODE_ON, 2'd1, 16'h0000);
        send_tick();
    endtask

    // A long interval: the count has to climb the whole way before the toggle.
    task automatic test_long_period();
        gaps_enabled = 1'b0;
        send_request(lbc_pkg::MODE_BLINK, 2'd3, 16'(LONG_PERIOD));
        repeat (LONG_PERIOD - 1) send_tick();
        send_tick();
        send_request(lbc_pkg::MODE_STOP_BLINK, 2'd3, 16'h0000);
        gaps_enabled = 1'b1;
    endtask

    // Random requests weighted towards blinking with short intervals and ticks.
    task automatic test_random(int count);
        int             pick;
        int             stretch;
        lbc_pkg::mode_t mode;
        logic [15:0]    period;
        stretch = $urandom_range(100, 250);
        for (int n = 0; n < count; n++) begin
            if (stretch == 0) begin
                gaps_enabled = ~gaps_enabled;
                stretch = $urandom_range(100, 250);
            end
            stretch--;
            pick = $urandom_range(0, 99);
            if (pick < 45)      mode = lbc_pkg::MODE_TICK;
            else if (pick < 57) mode = lbc_pkg::MODE_BLINK;
            else if (pick < 65) mode = lbc_pkg::MODE_ON;
            else if (pick < 72) mode = lbc_pkg::MODE_OFF;
            else if (pick < 80) mode = lbc_pkg::MODE_TOGGLE;
            else if (pick < 85) mode = lbc_pkg::MODE_ALL_ON;
            else if (pick < 90) mode = lbc_pkg::MODE_ALL_OFF;
            else                mode = lbc_pkg::MODE_STOP_BLINK;
            pick = $urandom_range(0, 9);
            if (pick < 8)       period = 16'($urandom_range(0, 6));
            else if (pick < 9)  period = 16'($urandom_range(7, 40));
            else                period = 16'($urandom);
            send_request(mode, 2'($urandom_range(0, 3)), period);
        end
        gaps_enabled = 1'b1;
    endtask

    // Receiver back-pressure: a style is held for a while, then another is drawn.
    initial begin : result_stalls
        int   style;
        int   style_left;
        int   run_left;
        int   phase;
        logic ready_now;
        style_left = 0;
        run_left   = 0;
        phase      = 0;
        ready_now  = 1'b1;
        forever begin
            @(negedge aclk);
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(40, 200);
            end
            style_left--;
            case (style)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: begin
                    m_tready <= (phase % 4 == 0);
                    phase++;
                end
                default: begin
                    if (run_left == 0) begin
                        ready_now = ~ready_now;
                        run_left  = $urandom_range(1, 12);
                    end
                    run_left--;
                    m_tready <= ready_now;
                end
            endcase
        end
    end

    // Each accepted result is compared with the oldest outstanding mask.
    always @(posedge aclk) begin : check_results
        logic [MASK_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_masks.size() == 0) begin
                $error("led_mask: no result expected, actual %h", m_tdata[MASK_W-1:0]);
                mismatches++;
            end else begin
                want = expected_masks.pop_front();
                if (m_tdata[MASK_W-1:0] !== want) begin
                    $error("led_mask: expected %h, actual %h", want, m_tdata[MASK_W-1:0]);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence.
    initial begin : main_sequence
        int waited;
        led_levels = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            blink_armed[i]    = 1'b0;
            tick_count[i]     = '0;
            blink_interval[i] = '0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_single_commands();
        test_group_commands();
        test_zero_period();
        test_blink_intervals();
        test_random(1000);
        test_long_period();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_masks.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_masks.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog in case the handshakes stop moving.
    initial begin : watchdog
        #60_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
